// ===== hdl/efe_pkg.sv =====
// shared constants and types of the elias-fano encoder
package efe_pkg;

    // default sizing, handed to the top level parameters
    localparam int MAX_ELEMS_DEF  = 32;
    localparam int VALUE_BITS_DEF = 32;

    // fixed field widths of the stream payloads
    localparam int IN_VALUE_W  = 32;
    localparam int COUNT_W     = 6;
    localparam int LOW_WIDTH_W = 6;
    localparam int HIGH_LEN_W  = 7;
    localparam int LOW_VALUE_W = 32;
    localparam int HIGH_POS_W  = 6;
    localparam int OUT_TDATA_W = 64;
    localparam int OUT_PAD_W   = OUT_TDATA_W - (COUNT_W + LOW_WIDTH_W + HIGH_LEN_W
                                 + LOW_VALUE_W + HIGH_POS_W + 2);

    // result kind carried on tuser
    typedef enum logic {
        KIND_HEADER  = 1'b0,
        KIND_ELEMENT = 1'b1
    } kind_t;

endpackage

// ===== hdl/efe_width.sv =====
// iterative search for the low-part width: smallest l with n << l >= m
module efe_width #(
    parameter int VALUE_BITS = efe_pkg::VALUE_BITS_DEF,
    parameter int CNT_W      = 6,
    parameter int LW_W       = 6
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [CNT_W-1:0]      n,
    input  logic [VALUE_BITS-1:0] m,
    output logic                  done,
    output logic [LW_W-1:0]       width
);

    localparam int SH_W = CNT_W + VALUE_BITS;

    logic [SH_W-1:0] sh_reg, sh_next;
    logic [LW_W-1:0] l_reg, l_next;
    logic            busy_reg, busy_next;
    logic [SH_W-1:0] m_ext;
    logic            hit;

    assign m_ext = SH_W'(m);
    assign hit   = (sh_reg >= m_ext);
    assign done  = busy_reg && hit;
    assign width = l_reg;

    always_comb
    begin
        sh_next   = sh_reg;
        l_next    = l_reg;
        busy_next = busy_reg;
        if (start)
        begin
            sh_next   = SH_W'(n);
            l_next    = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (hit)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                sh_next = sh_reg << 1;
                l_next  = l_reg + LW_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sh_reg   <= '0;
            l_reg    <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            sh_reg   <= sh_next;
            l_reg    <= l_next;
            busy_reg <= busy_next;
        end
    end

`ifndef SYNTHESIS
    // the width found is the smallest one
    a_width_minimal: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((l_reg == '0) || ((sh_reg >> 1) < m_ext)))
        else $error("width search overshot");

    // the search never runs past the value width
    a_width_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (l_reg <= LW_W'(VALUE_BITS)))
        else $error("width search out of range");

    // each step without a hit advances the width by one
    a_width_step: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !done && !start) |=> (l_reg == $past(l_reg) + LW_W'(1)))
        else $error("width search step lost");
`endif

endmodule

// ===== hdl/elias_fano_encoder_core.sv =====
// top level of the elias-fano list encoder
// Loads a sorted list of values, one per input transaction, into an on-chip element
// store until the transaction with tlast; that element is stored too. While loading the
// block takes one value per cycle and keeps a running maximum, an order check and a
// count. Values beyond MAX_ELEMS are dropped and raise the overflow flag; a value
// smaller than its predecessor raises the unsorted flag. After tlast the low-part width
// L is found by a shift-and-compare unit, one candidate per cycle. Then one header
// transaction (tuser = 0) carries count, L and high-array length, followed by one
// element transaction (tuser = 1) per stored value, in order, giving its low L bits and
// its set-bit position in the high array; tlast marks the last result of the run. The
// element results stream at one per cycle while the output is not stalled by m_tready,
// fed by the single registered read port of the store. No new values are taken until
// all results of a run have been handed to the output register; the last result may
// still wait there while the next list loads. The store needs no clearing pass: only
// entries written in the current run are read.
module elias_fano_encoder_core #(
    parameter int MAX_ELEMS  = efe_pkg::MAX_ELEMS_DEF,
    parameter int VALUE_BITS = efe_pkg::VALUE_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [efe_pkg::IN_VALUE_W-1:0]   s_tdata,   // [31:0] value
    input  logic                             s_tlast,   // last element of the list
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [5:0] count, [11:6] low_width, [18:12] high_len, [50:19] low_value,
    // [56:51] high_pos, [57] unsorted, [58] overflow, [63:59] zero
    output logic [efe_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic                             m_tuser,   // kind: 0 header, 1 element
    output logic                             m_tlast    // end of run
);

    localparam int CNT_W  = $clog2(MAX_ELEMS + 1);
    localparam int ADDR_W = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
    localparam int LW_W   = $clog2(VALUE_BITS + 1);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_WIDTH,
        ST_HEAD,
        ST_EMIT
    } state_t;

    // control state
    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0] max_reg, max_next;
    logic [VALUE_BITS-1:0] prev_reg, prev_next;
    logic                unsorted_reg, unsorted_next;
    logic                overflow_reg, overflow_next;
    logic [CNT_W-1:0]    iss_reg, iss_next;       // reads issued to the store
    logic [CNT_W-1:0]    idx_reg, idx_next;       // index of the word in rd_data_reg
    logic                pend_reg, pend_next;     // rd_data_reg holds an unused word

    // output register
    logic                                out_valid_reg, out_valid_next;
    efe_pkg::kind_t                      out_kind_reg, out_kind_next;
    logic [efe_pkg::COUNT_W-1:0]         out_count_reg, out_count_next;
    logic [efe_pkg::LOW_WIDTH_W-1:0]     out_lw_reg, out_lw_next;
    logic [efe_pkg::HIGH_LEN_W-1:0]      out_hl_reg, out_hl_next;
    logic [efe_pkg::LOW_VALUE_W-1:0]     out_lv_reg, out_lv_next;
    logic [efe_pkg::HIGH_POS_W-1:0]      out_hp_reg, out_hp_next;
    logic                                out_uns_reg, out_uns_next;
    logic                                out_ovf_reg, out_ovf_next;
    logic                                out_eor_reg, out_eor_next;

    // element store
    logic [VALUE_BITS-1:0] store_mem [MAX_ELEMS];
    logic [VALUE_BITS-1:0] rd_data_reg;
    logic                  wr_en;
    logic                  rd_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [ADDR_W-1:0]     rd_addr;

    logic [VALUE_BITS-1:0] in_value;
    logic                  in_fire;
    logic                  out_free;
    logic                  consume;
    logic                  ws_start;
    logic                  ws_done;
    logic [LW_W-1:0]       ws_width;
    logic [VALUE_BITS-1:0] low_mask;

    assign in_value = VALUE_BITS'(s_tdata);
    assign s_tready = (state_reg == ST_LOAD);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign consume  = (state_reg == ST_EMIT) && pend_reg && out_free;
    assign rd_en    = (state_reg == ST_EMIT) && (iss_reg < cnt_reg) && (!pend_reg || consume);
    assign wr_en    = in_fire && (cnt_reg < CNT_W'(MAX_ELEMS));
    assign wr_addr  = cnt_reg[ADDR_W-1:0];
    assign rd_addr  = iss_reg[ADDR_W-1:0];
    assign ws_start = in_fire && s_tlast;
    assign low_mask = ~({VALUE_BITS{1'b1}} << ws_width);

    // low-part width search
    efe_width #(
        .VALUE_BITS (VALUE_BITS),
        .CNT_W      (CNT_W),
        .LW_W       (LW_W)
    ) u_width (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ws_start),
        .n     (cnt_next),
        .m     (max_reg),
        .done  (ws_done),
        .width (ws_width)
    );

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        max_next       = max_reg;
        prev_next      = prev_reg;
        unsorted_next  = unsorted_reg;
        overflow_next  = overflow_reg;
        iss_next       = iss_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_kind_next  = out_kind_reg;
        out_count_next = out_count_reg;
        out_lw_next    = out_lw_reg;
        out_hl_next    = out_hl_reg;
        out_lv_next    = out_lv_reg;
        out_hp_next    = out_hp_reg;
        out_uns_next   = out_uns_reg;
        out_ovf_next   = out_ovf_reg;
        out_eor_next   = out_eor_reg;

        case (state_reg)
            ST_LOAD:
            begin
                if (in_fire)
                begin
                    // order check sees dropped values too
                    if (in_value < prev_reg)
                    begin
                        unsorted_next = 1'b1;
                    end
                    prev_next = in_value;
                    if (wr_en)
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                        if (in_value > max_reg)
                        begin
                            max_next = in_value;
                        end
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                    if (s_tlast)
                    begin
                        state_next = ST_WIDTH;
                    end
                end
            end

            ST_WIDTH:
            begin
                if (ws_done)
                begin
                    state_next = ST_HEAD;
                end
            end

            ST_HEAD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = efe_pkg::KIND_HEADER;
                    out_count_next = efe_pkg::COUNT_W'(cnt_reg);
                    out_lw_next    = efe_pkg::LOW_WIDTH_W'(ws_width);
                    out_hl_next    = efe_pkg::HIGH_LEN_W'(cnt_reg)
                                     + efe_pkg::HIGH_LEN_W'(max_reg >> ws_width);
                    out_lv_next    = '0;
                    out_hp_next    = '0;
                    out_uns_next   = unsorted_reg;
                    out_ovf_next   = overflow_reg;
                    out_eor_next   = (cnt_reg == '0);
                    iss_next       = '0;
                    pend_next      = 1'b0;
                    if (cnt_reg == '0)
                    begin
                        // empty run ends with the header
                        state_next    = ST_LOAD;
                        max_next      = '0;
                        prev_next     = '0;
                        unsorted_next = 1'b0;
                        overflow_next = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end

            ST_EMIT:
            begin
                if (consume)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = efe_pkg::KIND_ELEMENT;
                    out_count_next = '0;
                    out_lw_next    = '0;
                    out_hl_next    = '0;
                    out_lv_next    = efe_pkg::LOW_VALUE_W'(rd_data_reg & low_mask);
                    out_hp_next    = efe_pkg::HIGH_POS_W'(rd_data_reg >> ws_width)
                                     + efe_pkg::HIGH_POS_W'(idx_reg);
                    out_uns_next   = unsorted_reg;
                    out_ovf_next   = overflow_reg;
                    out_eor_next   = (idx_reg == cnt_reg - CNT_W'(1));
                    pend_next      = 1'b0;
                    if (idx_reg == cnt_reg - CNT_W'(1))
                    begin
                        // run complete, ready for the next list
                        state_next    = ST_LOAD;
                        cnt_next      = '0;
                        max_next      = '0;
                        prev_next     = '0;
                        unsorted_next = 1'b0;
                        overflow_next = 1'b0;
                    end
                end
                if (rd_en)
                begin
                    idx_next  = iss_reg;
                    iss_next  = iss_reg + CNT_W'(1);
                    pend_next = 1'b1;
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            cnt_reg       <= '0;
            max_reg       <= '0;
            prev_reg      <= '0;
            unsorted_reg  <= 1'b0;
            overflow_reg  <= 1'b0;
            iss_reg       <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_kind_reg  <= efe_pkg::KIND_HEADER;
            out_count_reg <= '0;
            out_lw_reg    <= '0;
            out_hl_reg    <= '0;
            out_lv_reg    <= '0;
            out_hp_reg    <= '0;
            out_uns_reg   <= 1'b0;
            out_ovf_reg   <= 1'b0;
            out_eor_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            max_reg       <= max_next;
            prev_reg      <= prev_next;
            unsorted_reg  <= unsorted_next;
            overflow_reg  <= overflow_next;
            iss_reg       <= iss_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            out_kind_reg  <= out_kind_next;
            out_count_reg <= out_count_next;
            out_lw_reg    <= out_lw_next;
            out_hl_reg    <= out_hl_next;
            out_lv_reg    <= out_lv_next;
            out_hp_reg    <= out_hp_next;
            out_uns_reg   <= out_uns_next;
            out_ovf_reg   <= out_ovf_next;
            out_eor_reg   <= out_eor_next;
        end
    end

    // element store: one write port while loading, one registered read port while emitting
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= in_value;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_eor_reg;
    assign m_tdata  = {{efe_pkg::OUT_PAD_W{1'b0}}, out_ovf_reg, out_uns_reg, out_hp_reg,
                       out_lv_reg, out_hl_reg, out_lw_reg, out_count_reg};

`ifndef SYNTHESIS
    // the fill count never passes the store depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_ELEMS))
        else $error("element count beyond store depth");

    // no store word is left over once loading resumes
    a_no_pending_in_load: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !pend_reg)
        else $error("store read pending while loading");

    // reads never run past the stored elements
    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (iss_reg <= cnt_reg))
        else $error("store read beyond element count");
`endif

endmodule
